// ===== hdl/see_pkg.sv =====
// Shared types, character constants and lookup functions for the string escape encoder.
// Used by the front end, the descriptor queue, the back end and the top level.
package see_pkg;

  // Default depth of the queue between the front end and the back end.
  localparam int unsigned QueueDepthDefault = 2;

  // Character codes that the encoder emits.
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharX         = 8'h78;
  localparam logic [7:0] CharNul       = 8'h00;

  // How a byte is written out.
  typedef enum logic [1:0] {
    KIND_CLOSE = 2'd0,  // terminating zero: closing quote
    KIND_LIT   = 2'd1,  // printable byte, passed through
    KIND_ESC   = 2'd2,  // backslash and one letter
    KIND_HEX   = 2'd3   // backslash, x and two hex digits
  } char_kind_e;

  // One classified byte on its way from the front end to the back end.
  typedef struct packed {
    logic       open_quote;  // an opening quote goes first
    char_kind_e kind;
    logic [7:0] data_byte;
  } desc_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Letter of a two-character escape, or NUL if the byte has none.
  function automatic logic [7:0] escape_letter(input logic [7:0] b);
    logic [7:0] letter;
    case (b)
      8'd34:   letter = CharQuote;
      8'd92:   letter = CharBackslash;
      8'd10:   letter = 8'h6e;  // n
      8'd13:   letter = 8'h72;  // r
      8'd9:    letter = 8'h74;  // t
      8'd12:   letter = 8'h66;  // f
      8'd11:   letter = 8'h76;  // v
      8'd8:    letter = 8'h62;  // b
      default: letter = CharNul;
    endcase
    return letter;
  endfunction

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] digit;
    if (nib < 4'd10) begin
      digit = 8'h30 + {4'd0, nib};
    end else begin
      digit = 8'h57 + {4'd0, nib};
    end
    return digit;
  endfunction

endpackage

// ===== hdl/see_front.sv =====
// Front end of the string escape encoder: accepts bytes and classifies them.
// Depends on see_pkg for the descriptor type and the escape lookup.
module see_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              queue_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output see_pkg::desc_t    desc_o
);

  logic quote_opened_q;
  logic quote_opened_d;
  logic accept;

  // A transaction is taken whenever the queue has room.
  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;

  // Classify the byte and note whether an opening quote is due.
  always_comb begin
    desc_o.open_quote = !quote_opened_q;
    desc_o.data_byte  = data_byte_i;
    if (data_byte_i == see_pkg::CharNul) begin
      desc_o.kind = see_pkg::KIND_CLOSE;
    end else if (data_byte_i inside {[8'd32:8'd126]} &&
                 data_byte_i != see_pkg::CharQuote &&
                 data_byte_i != see_pkg::CharBackslash) begin
      desc_o.kind = see_pkg::KIND_LIT;
    end else if (see_pkg::escape_letter(data_byte_i) != see_pkg::CharNul) begin
      desc_o.kind = see_pkg::KIND_ESC;
    end else begin
      desc_o.kind = see_pkg::KIND_HEX;
    end
  end

  // A string stays open until its terminating zero is taken.
  always_comb begin
    quote_opened_d = quote_opened_q;
    if (accept) begin
      quote_opened_d = (data_byte_i != see_pkg::CharNul);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_opened_q <= 1'b0;
    end else begin
      quote_opened_q <= quote_opened_d;
    end
  end

endmodule

// ===== hdl/see_queue.sv =====
// Short descriptor queue between the front end and the back end.
// Depends on see_pkg for the descriptor and status types.
module see_queue #(
  parameter int unsigned Depth = see_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  see_pkg::desc_t        desc_i,
  input  logic                  pop_i,
  output see_pkg::desc_t        desc_o,
  output see_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne  = PtrW'(1);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  see_pkg::desc_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (count_q == CntFull);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign desc_o  = entries_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrOne;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrOne;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntOne;
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

// ===== hdl/see_back.sv =====
// Back end of the string escape encoder: expands one descriptor into characters.
// Depends on see_pkg for the descriptor type and the character lookups.
module see_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  see_pkg::desc_t desc_i,
  input  logic           queue_empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_char_o,
  output logic           run_last_o,
  output logic           string_done_o
);

  logic [2:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q;
  logic       run_last_q;
  logic       string_done_q;
  logic       load;
  logic       fire;
  logic [2:0] base_len;
  logic [2:0] total_len;
  logic [2:0] step;
  logic       is_last;
  logic [7:0] next_char;

  // The output register takes a new character when it is empty or being drained.
  assign load = !out_valid_q || !out_stall_i;
  assign fire = load && !queue_empty_i;

  // Length of the expansion and position within the encoded byte.
  always_comb begin
    case (desc_i.kind)
      see_pkg::KIND_CLOSE: base_len = 3'd1;
      see_pkg::KIND_LIT:   base_len = 3'd1;
      see_pkg::KIND_ESC:   base_len = 3'd2;
      see_pkg::KIND_HEX:   base_len = 3'd4;
      default:             base_len = 3'd1;
    endcase
    total_len = base_len + {2'b00, desc_i.open_quote};
    step      = pos_q - {2'b00, desc_i.open_quote};
    is_last   = (pos_q == total_len - 3'd1);
  end

  // Character at the current position.
  always_comb begin
    if (desc_i.open_quote && pos_q == 3'd0) begin
      next_char = see_pkg::CharQuote;
    end else begin
      case (desc_i.kind)
        see_pkg::KIND_CLOSE: next_char = see_pkg::CharQuote;
        see_pkg::KIND_LIT:   next_char = desc_i.data_byte;
        see_pkg::KIND_ESC: begin
          next_char = (step == 3'd0) ? see_pkg::CharBackslash
                                     : see_pkg::escape_letter(desc_i.data_byte);
        end
        see_pkg::KIND_HEX: begin
          case (step)
            3'd0:    next_char = see_pkg::CharBackslash;
            3'd1:    next_char = see_pkg::CharX;
            3'd2:    next_char = see_pkg::hex_digit(desc_i.data_byte[7:4]);
            default: next_char = see_pkg::hex_digit(desc_i.data_byte[3:0]);
          endcase
        end
        default: next_char = see_pkg::CharQuote;
      endcase
    end
  end

  // Position counter and output valid.
  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = !queue_empty_i;
    end
    if (fire) begin
      pos_d = is_last ? 3'd0 : pos_q + 3'd1;
    end
  end

  assign pop_o = fire && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_char_q    <= next_char;
      run_last_q    <= is_last;
      string_done_q <= is_last && (desc_i.kind == see_pkg::KIND_CLOSE);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign run_last_o    = run_last_q;
  assign string_done_o = string_done_q;

endmodule

// ===== hdl/string_escape_encoder_unit.sv =====
// String escape encoder: turns a NUL-terminated byte stream into a quoted C literal.
// Each accepted byte yields one to five characters (four for a hex escape, five
// when it also opens a string), one per clock cycle at the output while the queue
// holds a byte and out_stall_i is low; that one-character-per-cycle back end sets
// the sustained input rate. The front end takes a new byte every cycle while the
// descriptor queue has room, so bytes queue up while earlier ones are still being
// expanded. run_last_o marks the last character of each byte and string_done_o the
// closing quote. A byte's first character passes the queue, then the output register.
// Depends on see_pkg, see_front, see_queue and see_back.
module string_escape_encoder_unit #(
  parameter int unsigned QueueDepth = see_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       string_done_o
);

  see_pkg::desc_t         push_desc;
  see_pkg::desc_t         head_desc;
  see_pkg::queue_status_t q_status;
  logic                   push;
  logic                   pop;

  // Front end: accept and classify.
  see_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .data_byte_i  (data_byte_i),
    .queue_full_i (q_status.full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  // Queue of classified bytes.
  see_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (push_desc),
    .pop_i    (pop),
    .desc_o   (head_desc),
    .status_o (q_status)
  );

  // Back end: expand into characters.
  see_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_i        (head_desc),
    .queue_empty_i (q_status.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

`ifndef SYNTHESIS
  // A closing quote is always the last character of its byte.
  a_done_is_last_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o && out_char_o == see_pkg::CharQuote)
    else $error("string_done without a final closing quote");

  // The queue can never be full and empty at once.
  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // Output turns valid only after the queue held a descriptor.
  a_valid_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_status.empty))
    else $error("output valid without a queued descriptor");

  // The queue is only popped while it holds an entry.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from an empty queue");
`endif

endmodule
